/* hw/rtl/bmf_pkg.sv */
// Shared constants and types for the box mean filter core.
package bmf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIX_W     = 8;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 13;
    localparam int CFG_W     = 13;
    localparam int ROW_W     = 14;
    localparam int MIN_DIM   = 5;

    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(512);
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(512);

    // floor(s/9) and floor(s/25) as (s * recip) >> 17, exact for s < 32768
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_3X3 = RECIP_W'(14564);
    localparam logic [RECIP_W-1:0] RECIP_5X5 = RECIP_W'(5243);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WINDOW_MODE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic interior;
        logic mode;
    } meta_t;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pixel;
    } out_item_t;

endpackage

/* hw/rtl/bmf_ram.sv */
// Generic single-write, single-read RAM with registered read (read-first).
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/box_mean_filter_3x3_5x5_core.sv */
// Top level: streaming 3x3 / 5x5 box mean filter with four line buffers.
// Throughput: one item per clock while s_axis_tready is high. Results trail the input by
// two rows plus two pixels, through the stage registers and the output queue to m_axis.
// Window step, row sums and total take one register stage each; reciprocal multiply has none.
// Up to 8 items may be outstanding (stages plus the output queue) before s_axis_tready drops.
// aresetn (synchronous, active low) clears counters, window, queue and config registers;
// the line buffers are not cleared and need no clearing pass.
module box_mean_filter_3x3_5x5_core #(
    parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0] cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tuser,   // [0] is_fill
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic        m_axis_tlast    // last_of_frame
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WCW > bmf_pkg::IMG_W_W) ? WCW : bmf_pkg::IMG_W_W;
    localparam int PW    = bmf_pkg::PIX_W;
    localparam int RW    = bmf_pkg::ROW_W;
    localparam int RSW   = 11;
    localparam int SUMW  = 13;
    localparam int PRODW = SUMW + bmf_pkg::RECIP_W;
    localparam int CNTW  = bmf_pkg::FIFO_AW + 1;
    localparam int OUTW  = CNTW + 1;

    // ---------------- configuration ----------------
    logic [bmf_pkg::IMG_W_W-1:0] image_width_reg;
    logic [bmf_pkg::IMG_H_W-1:0] image_height_reg;
    logic                        window_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= bmf_pkg::IMG_W_RESET;
            image_height_reg <= bmf_pkg::IMG_H_RESET;
            window_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (bmf_pkg::cfg_reg_t'(cfg_index))
                bmf_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata[bmf_pkg::IMG_W_W-1:0];
                end
                bmf_pkg::REG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_wdata[bmf_pkg::IMG_H_W-1:0];
                end
                bmf_pkg::REG_WINDOW_MODE: begin
                    window_mode_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size, width clamped to [5, MAX_WIDTH], height to at least 5
    logic [CMPW-1:0] iw_ext;
    logic [WCW-1:0]  eff_w;
    logic [RW-1:0]   eff_h;

    always_comb begin
        iw_ext = CMPW'(image_width_reg);
        if (iw_ext < CMPW'(bmf_pkg::MIN_DIM)) begin
            eff_w = WCW'(bmf_pkg::MIN_DIM);
        end else if (iw_ext > CMPW'(MAX_WIDTH)) begin
            eff_w = WCW'(MAX_WIDTH);
        end else begin
            eff_w = WCW'(iw_ext);
        end
        if (image_height_reg < bmf_pkg::IMG_H_W'(bmf_pkg::MIN_DIM)) begin
            eff_h = RW'(bmf_pkg::MIN_DIM);
        end else begin
            eff_h = RW'(image_height_reg);
        end
    end

    // ---------------- position counters ----------------
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;

    logic          s_acc;
    logic          draining;
    logic          take;
    logic [PW-1:0] pix_now;
    logic          in_wrap;
    logic          out_wrap;
    logic [WCW:0]  ocol_ext;
    logic [WCW:0]  w_ext;
    bmf_pkg::meta_t meta_now;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign draining = in_row_reg >= eff_h;
    // a fill item before the frame is complete changes nothing
    assign take     = s_acc && !(s_axis_tuser && !draining);
    assign pix_now  = draining ? '0 : s_axis_tdata[PW-1:0];

    assign in_wrap  = (WCW'(in_col_reg) + WCW'(1)) >= eff_w;
    assign out_wrap = (WCW'(out_col_reg) + WCW'(1)) >= eff_w;
    assign ocol_ext = (WCW + 1)'(out_col_reg);
    assign w_ext    = (WCW + 1)'(eff_w);

    always_comb begin
        meta_now.emit     = (in_row_reg > RW'(2))
                         || (in_row_reg == RW'(2) && in_col_reg >= AW'(2));
        meta_now.last     = ((out_row_reg + RW'(1)) >= eff_h) && out_wrap;
        meta_now.interior = (out_row_reg >= RW'(2)) && ((out_row_reg + RW'(2)) < eff_h)
                         && (out_col_reg >= AW'(2)) && ((ocol_ext + (WCW + 1)'(2)) < w_ext);
        meta_now.mode     = window_mode_reg;
    end

    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (take) begin
            if (in_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + AW'(1);
            end
            if (meta_now.emit) begin
                if (meta_now.last) begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end else if (out_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // ---------------- line buffers: one RAM per row slot ----------------
    logic [PW-1:0] ram_rd [4];

    for (genvar k = 0; k < 4; k++) begin : g_line
        bmf_ram #(
            .WIDTH (PW),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .aclk  (aclk),
            .we    (take && (in_row_reg[1:0] == 2'(k))),
            .waddr (in_col_reg),
            .wdata (pix_now),
            .re    (take),
            .raddr (in_col_reg),
            .rdata (ram_rd[k])
        );
    end

    // ---------------- stage 1: line data arrives ----------------
    logic           st1_valid_reg;
    logic [PW-1:0]  st1_pix_reg;
    logic [1:0]     st1_slot_reg;
    bmf_pkg::meta_t st1_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            st1_pix_reg  <= pix_now;
            st1_slot_reg <= in_row_reg[1:0];
            st1_meta_reg <= meta_now;
        end
    end

    // ---------------- stage 2: window shift ----------------
    logic [PW-1:0]  win_reg [5][5];
    logic [PW-1:0]  col_in [5];
    logic           st2_valid_reg;
    bmf_pkg::meta_t st2_meta_reg;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            col_in[r] = ram_rd[2'(st1_slot_reg + 2'(r))];
        end
        col_in[4] = st1_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 5; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            st2_valid_reg <= st1_valid_reg;
            if (st1_valid_reg) begin
                for (int r = 0; r < 5; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        win_reg[r][c] <= win_reg[r][c + 1];
                    end
                    win_reg[r][4] <= col_in[r];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_valid_reg) begin
            st2_meta_reg <= st1_meta_reg;
        end
    end

    // ---------------- stage 3: row sums ----------------
    logic [RSW-1:0] row_sum [5];
    logic [RSW-1:0] st3_rsum_reg [5];
    logic [PW-1:0]  st3_centre_reg;
    logic           st3_valid_reg;
    bmf_pkg::meta_t st3_meta_reg;

    always_comb begin
        for (int r = 0; r < 5; r++) begin
            if (st2_meta_reg.mode) begin
                row_sum[r] = RSW'(win_reg[r][0]) + RSW'(win_reg[r][1]) + RSW'(win_reg[r][2])
                           + RSW'(win_reg[r][3]) + RSW'(win_reg[r][4]);
            end else if (r >= 1 && r <= 3) begin
                row_sum[r] = RSW'(win_reg[r][1]) + RSW'(win_reg[r][2]) + RSW'(win_reg[r][3]);
            end else begin
                row_sum[r] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
        end else begin
            st3_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st2_valid_reg) begin
            for (int r = 0; r < 5; r++) begin
                st3_rsum_reg[r] <= row_sum[r];
            end
            st3_centre_reg <= win_reg[2][2];
            st3_meta_reg   <= st2_meta_reg;
        end
    end

    // ---------------- stage 4: window total ----------------
    logic [SUMW-1:0] st4_total_reg;
    logic [PW-1:0]   st4_centre_reg;
    logic            st4_valid_reg;
    bmf_pkg::meta_t  st4_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st4_valid_reg <= 1'b0;
        end else begin
            st4_valid_reg <= st3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st3_valid_reg) begin
            st4_total_reg  <= SUMW'(st3_rsum_reg[0]) + SUMW'(st3_rsum_reg[1])
                            + SUMW'(st3_rsum_reg[2]) + SUMW'(st3_rsum_reg[3])
                            + SUMW'(st3_rsum_reg[4]);
            st4_centre_reg <= st3_centre_reg;
            st4_meta_reg   <= st3_meta_reg;
        end
    end

    // ---------------- reciprocal multiply into the output queue ----------------
    logic [bmf_pkg::RECIP_W-1:0] recip;
    logic [PRODW-1:0]            prod;
    bmf_pkg::out_item_t          push_item;
    logic                        push;

    assign recip = st4_meta_reg.mode ? bmf_pkg::RECIP_5X5 : bmf_pkg::RECIP_3X3;
    assign prod  = PRODW'(st4_total_reg) * PRODW'(recip);

    always_comb begin
        push_item.last  = st4_meta_reg.last;
        push_item.pixel = st4_meta_reg.interior ? prod[bmf_pkg::RECIP_SHIFT +: PW]
                                                : st4_centre_reg;
    end

    assign push = st4_valid_reg && st4_meta_reg.emit;

    // output queue; the credit check on s_axis_tready keeps it from overflowing
    bmf_pkg::out_item_t          fifo_mem [bmf_pkg::FIFO_DEPTH];
    logic [bmf_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [bmf_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [CNTW-1:0]             fifo_cnt_reg, fifo_cnt_next;
    logic                        pop;
    logic [OUTW-1:0]             outstanding;
    bmf_pkg::out_item_t          head;

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_mem[rd_ptr_reg];

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop) begin
            fifo_cnt_next = fifo_cnt_reg + CNTW'(1);
        end else if (!push && pop) begin
            fifo_cnt_next = fifo_cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + bmf_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + bmf_pkg::FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    assign outstanding = OUTW'(fifo_cnt_reg) + OUTW'(st1_valid_reg) + OUTW'(st2_valid_reg)
                       + OUTW'(st3_valid_reg) + OUTW'(st4_valid_reg);

    assign s_axis_tready = outstanding < OUTW'(bmf_pkg::FIFO_DEPTH);
    assign m_axis_tvalid = fifo_cnt_reg != '0;
    assign m_axis_tdata  = head.pixel;
    assign m_axis_tlast  = head.last;

    // ---------------- assertions ----------------
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg < CNTW'(bmf_pkg::FIFO_DEPTH)) || pop)
        else $error("output queue written while full");

    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding <= OUTW'(bmf_pkg::FIFO_DEPTH))
        else $error("more items outstanding than the queue can hold");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && meta_now.emit && meta_now.last) |=>
            (in_row_reg == '0 && in_col_reg == '0 && out_row_reg == '0 && out_col_reg == '0))
        else $error("counters not cleared after the last item of a frame");

    a_last_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && meta_now.emit && meta_now.last) |-> ##4 push && push_item.last)
        else $error("last-of-frame item did not reach the queue on time");

    a_ignored_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !take) |=> $stable(in_row_reg) && $stable(in_col_reg) && !st1_valid_reg)
        else $error("ignored fill item changed state");

endmodule
